FILE: hdl/lsi_pkg.sv
// Shared widths and the divider chain transaction type for the line
// segment intersection unit. No dependencies.
package lsi_pkg;
    localparam int COORD_BITS = 16;
    // direction and offset differences
    localparam int DW = COORD_BITS + 1;
    // cross products and their differences
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    // point numerator den*base + num*dir
    localparam int TW = NW + DW + 1;
    localparam int IN_BYTES  = (8 * COORD_BITS + 7) / 8;
    localparam int OUT_BITS  = 2 * COORD_BITS + 1;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // one transaction moving down the divider chain
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic                  neg_x;
        logic                  neg_y;
        logic [TW-1:0]         rem_x;
        logic [TW-1:0]         rem_y;
        logic [TW-1:0]         dsh;
        logic [COORD_BITS-1:0] q_x;
        logic [COORD_BITS-1:0] q_y;
    } lsi_div_t;
endpackage

FILE: hdl/line_segment_intersection_unit.sv
// Top level of the line segment intersection unit: front pipeline, divider
// cell chain and output register. Depends on lsi_pkg, lsi_front, lsi_div_cell.
//
// Usage:
//   s_axis: one transaction per segment pair, eight signed coordinates in
//   s_tdata (P1.x, P1.y, P2.x, P2.y, P3.x, P3.y, P4.x, P4.y, lowest first).
//   m_axis: one transaction per pair: hit, cross_x, cross_y (lowest first).
//   The path is six front stages, one divider cell per quotient bit and one
//   output register. Throughput is one pair per cycle while m_tready does not
//   hold the pipeline: every stage advances together and the divider is a
//   chain of cells, each retiring one quotient bit.
//   When m_tready is low and a result is waiting, the whole pipeline holds
//   and s_tready drops in the same cycle; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline; no result is
//   presented until new pairs arrive.
module line_segment_intersection_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [8*lsi_pkg::IN_BYTES-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, cross_x, cross_y, zero padding
    output logic [8*lsi_pkg::OUT_BYTES-1:0]     m_tdata
);
    localparam int C = lsi_pkg::COORD_BITS;

    logic en;
    logic m_tvalid_reg;
    logic [8*lsi_pkg::OUT_BYTES-1:0] m_tdata_reg, m_tdata_next;
    lsi_pkg::lsi_div_t chain [0:C];
    logic [C-1:0] cx, cy;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    lsi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata[8*C-1:0]),
        .out      (chain[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < C; i++) begin : g_cell
        lsi_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in      (chain[i]),
            .out     (chain[i+1])
        );
    end

    // sign restore and zeroing on miss
    always_comb begin
        cx = chain[C].neg_x ? C'(-chain[C].q_x) : chain[C].q_x;
        cy = chain[C].neg_y ? C'(-chain[C].q_y) : chain[C].q_y;
        m_tdata_next = '0;
        if (chain[C].hit) begin
            m_tdata_next[0]         = 1'b1;
            m_tdata_next[1 +: C]    = cx;
            m_tdata_next[C+1 +: C]  = cy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain[C].valid;
        end
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

FILE: hdl/lsi_front.sv
// Front pipeline: differences, cross products, hit test and point numerators.
// Depends on lsi_pkg.
module lsi_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [8*lsi_pkg::COORD_BITS-1:0]     in_data,
    output lsi_pkg::lsi_div_t                    out
);
    localparam int C = lsi_pkg::COORD_BITS;
    localparam int D = lsi_pkg::DW;
    localparam int P = lsi_pkg::PW;
    localparam int N = lsi_pkg::NW;
    localparam int T = lsi_pkg::TW;

    logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    assign x1 = in_data[0*C +: C];
    assign y1 = in_data[1*C +: C];
    assign x2 = in_data[2*C +: C];
    assign y2 = in_data[3*C +: C];
    assign x3 = in_data[4*C +: C];
    assign y3 = in_data[5*C +: C];
    assign x4 = in_data[6*C +: C];
    assign y4 = in_data[7*C +: C];

    logic [5:0] v_reg;

    // stage 1: differences
    logic signed [C-1:0]            s1_x1_reg, s1_y1_reg;
    logic signed [lsi_pkg::DW-1:0]  s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    logic signed [lsi_pkg::DW-1:0]  s1_ex_reg, s1_ey_reg;
    // stage 2: products
    logic signed [C-1:0]            s2_x1_reg, s2_y1_reg;
    logic signed [lsi_pkg::DW-1:0]  s2_dx1_reg, s2_dy1_reg;
    logic signed [lsi_pkg::PW-1:0]  s2_p0_reg, s2_p1_reg, s2_p2_reg;
    logic signed [lsi_pkg::PW-1:0]  s2_p3_reg, s2_p4_reg, s2_p5_reg;
    // stage 3: den, na, nb
    logic signed [C-1:0]            s3_x1_reg, s3_y1_reg;
    logic signed [lsi_pkg::DW-1:0]  s3_dx1_reg, s3_dy1_reg;
    logic signed [lsi_pkg::NW-1:0]  s3_den_reg, s3_na_reg, s3_nb_reg;
    // stage 4: normalized sign, hit
    logic signed [C-1:0]            s4_x1_reg, s4_y1_reg;
    logic signed [lsi_pkg::DW-1:0]  s4_dx1_reg, s4_dy1_reg;
    logic signed [lsi_pkg::NW-1:0]  s4_den_reg, s4_na_reg;
    logic                           s4_hit_reg;
    // stage 5: point products
    logic signed [lsi_pkg::TW-1:0]  s5_bx_reg, s5_by_reg, s5_mx_reg, s5_my_reg;
    logic signed [lsi_pkg::NW-1:0]  s5_den_reg;
    logic                           s5_hit_reg;
    // stage 6: chain entry
    logic                           s6_hit_reg, s6_neg_x_reg, s6_neg_y_reg;
    logic [T-1:0]                   s6_rem_x_reg, s6_rem_y_reg, s6_dsh_reg;

    // sign normalization and range test on stage 3
    logic signed [N-1:0]            den_n, na_n, nb_n;
    logic                           hit_n;
    // point products at their natural widths
    logic signed [N+C-1:0]          bx_p, by_p;
    logic signed [N+D-1:0]          mx_p, my_p;
    // point numerators
    logic signed [T-1:0]            tx, ty;

    always_comb begin
        if (s3_den_reg[N-1]) begin
            den_n = -s3_den_reg;
            na_n  = -s3_na_reg;
            nb_n  = -s3_nb_reg;
        end else begin
            den_n = s3_den_reg;
            na_n  = s3_na_reg;
            nb_n  = s3_nb_reg;
        end
        hit_n = (den_n != '0) && !na_n[N-1] && !nb_n[N-1] &&
                (na_n <= den_n) && (nb_n <= den_n);
    end

    assign bx_p = (N+C)'(s4_den_reg) * (N+C)'(s4_x1_reg);
    assign by_p = (N+C)'(s4_den_reg) * (N+C)'(s4_y1_reg);
    assign mx_p = (N+D)'(s4_na_reg) * (N+D)'(s4_dx1_reg);
    assign my_p = (N+D)'(s4_na_reg) * (N+D)'(s4_dy1_reg);

    assign tx = s5_bx_reg + s5_mx_reg;
    assign ty = s5_by_reg + s5_my_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // data stages
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            s1_x1_reg  <= x1;
            s1_y1_reg  <= y1;
            s1_dx1_reg <= D'(x2) - D'(x1);
            s1_dy1_reg <= D'(y2) - D'(y1);
            s1_dx2_reg <= D'(x4) - D'(x3);
            s1_dy2_reg <= D'(y4) - D'(y3);
            s1_ex_reg  <= D'(x1) - D'(x3);
            s1_ey_reg  <= D'(y1) - D'(y3);
            // stage 2
            s2_x1_reg  <= s1_x1_reg;
            s2_y1_reg  <= s1_y1_reg;
            s2_dx1_reg <= s1_dx1_reg;
            s2_dy1_reg <= s1_dy1_reg;
            s2_p0_reg  <= P'(s1_dy2_reg) * P'(s1_dx1_reg);
            s2_p1_reg  <= P'(s1_dx2_reg) * P'(s1_dy1_reg);
            s2_p2_reg  <= P'(s1_dx2_reg) * P'(s1_ey_reg);
            s2_p3_reg  <= P'(s1_dy2_reg) * P'(s1_ex_reg);
            s2_p4_reg  <= P'(s1_dx1_reg) * P'(s1_ey_reg);
            s2_p5_reg  <= P'(s1_dy1_reg) * P'(s1_ex_reg);
            // stage 3
            s3_x1_reg  <= s2_x1_reg;
            s3_y1_reg  <= s2_y1_reg;
            s3_dx1_reg <= s2_dx1_reg;
            s3_dy1_reg <= s2_dy1_reg;
            s3_den_reg <= N'(s2_p0_reg) - N'(s2_p1_reg);
            s3_na_reg  <= N'(s2_p2_reg) - N'(s2_p3_reg);
            s3_nb_reg  <= N'(s2_p4_reg) - N'(s2_p5_reg);
            // stage 4
            s4_x1_reg  <= s3_x1_reg;
            s4_y1_reg  <= s3_y1_reg;
            s4_dx1_reg <= s3_dx1_reg;
            s4_dy1_reg <= s3_dy1_reg;
            s4_den_reg <= den_n;
            s4_na_reg  <= na_n;
            s4_hit_reg <= hit_n;
            // stage 5
            s5_bx_reg  <= T'(bx_p);
            s5_by_reg  <= T'(by_p);
            s5_mx_reg  <= T'(mx_p);
            s5_my_reg  <= T'(my_p);
            s5_den_reg <= s4_den_reg;
            s5_hit_reg <= s4_hit_reg;
            // stage 6: magnitudes and divisor aligned to the top quotient bit
            s6_hit_reg   <= s5_hit_reg;
            s6_neg_x_reg <= tx[T-1];
            s6_neg_y_reg <= ty[T-1];
            s6_rem_x_reg <= tx[T-1] ? $unsigned(-tx) : $unsigned(tx);
            s6_rem_y_reg <= ty[T-1] ? $unsigned(-ty) : $unsigned(ty);
            s6_dsh_reg   <= T'($unsigned(s5_den_reg)) << (C - 1);
        end
    end

    // chain entry transaction
    always_comb begin
        out       = '0;
        out.valid = v_reg[5];
        out.hit   = s6_hit_reg;
        out.neg_x = s6_neg_x_reg;
        out.neg_y = s6_neg_y_reg;
        out.rem_x = s6_rem_x_reg;
        out.rem_y = s6_rem_y_reg;
        out.dsh   = s6_dsh_reg;
    end
endmodule

FILE: hdl/lsi_div_cell.sv
// One restoring divider cell: produces one quotient bit per lane.
// Depends on lsi_pkg.
module lsi_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  lsi_pkg::lsi_div_t in,
    output lsi_pkg::lsi_div_t out
);
    lsi_pkg::lsi_div_t out_reg, out_next;
    logic ge_x, ge_y;

    // compare and conditionally subtract the shifted divisor
    always_comb begin
        ge_x = in.rem_x >= in.dsh;
        ge_y = in.rem_y >= in.dsh;
        out_next       = in;
        out_next.rem_x = ge_x ? in.rem_x - in.dsh : in.rem_x;
        out_next.rem_y = ge_y ? in.rem_y - in.dsh : in.rem_y;
        out_next.q_x   = {in.q_x[lsi_pkg::COORD_BITS-2:0], ge_x};
        out_next.q_y   = {in.q_y[lsi_pkg::COORD_BITS-2:0], ge_y};
        out_next.dsh   = in.dsh >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= in.valid;
        end
        if (en) begin
            out_reg.hit   <= out_next.hit;
            out_reg.neg_x <= out_next.neg_x;
            out_reg.neg_y <= out_next.neg_y;
            out_reg.rem_x <= out_next.rem_x;
            out_reg.rem_y <= out_next.rem_y;
            out_reg.dsh   <= out_next.dsh;
            out_reg.q_x   <= out_next.q_x;
            out_reg.q_y   <= out_next.q_y;
        end
    end

    assign out = out_reg;
endmodule

FILE: verif/tb.sv
// Self-checking testbench for line_segment_intersection_unit: directed table
// plus constrained-shape random segment pairs, checked against an integer predictor.
// Depends on lsi_pkg and the RTL top level.
module tb;
    typedef logic [8*lsi_pkg::IN_BYTES-1:0]  pair_bus_t;
    typedef logic [8*lsi_pkg::OUT_BYTES-1:0] res_bus_t;

    typedef struct {
        logic                           hit;
        logic [lsi_pkg::COORD_BITS-1:0] x;
        logic [lsi_pkg::COORD_BITS-1:0] y;
    } crossing_t;

    typedef struct {
        pair_bus_t data;
        bit        typed;
        crossing_t want;
    } sent_pair_t;

    localparam int DIR_ROWS = 14;
    localparam int TAB_COLS = 12;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_tvalid = 1'b0;
    logic      s_tready;
    pair_bus_t s_tdata = '0;
    logic      m_tvalid;
    logic      m_tready = 1'b0;
    res_bus_t  m_tdata;

    sent_pair_t  pairs_in_flight[$];
    crossing_t   crossings_due[$];
    int          errors = 0;
    int          s_idle = 13;
    int          r_idle = 52;

    // columns: P1.x P1.y P2.x P2.y P3.x P3.y P4.x P4.y typed hit x y
    int dir_tab [DIR_ROWS][TAB_COLS] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        '{-100, -100, 100, 100, -100, 100, 100, -100, 1, 1, 0, 0},
        '{0, 0, 10, 0, 5, -5, 5, 5, 1, 1, 5, 0},
        '{0, 0, 10, 10, 10, 10, 20, 0, 1, 1, 10, 10},
        '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1, 1, 0, 0},
        '{0, 0, 10, 0, 0, 5, 10, 5, 1, 0, 0, 0},
        '{0, 0, 10, 0, 5, 0, 15, 0, 1, 0, 0, 0},
        '{0, 0, 1, 0, 5, -1, 5, 1, 1, 0, 0, 0},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, 0, 0, 5, 5, 1, 0, 0, 0},
        '{-7, 3, 9, -11, 2, 8, -3, -6, 0, 0, 0, 0},
        '{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 0, 0, 0, 0},
        '{3, -1, -20000, 30001, -32768, 0, 32767, 1, 0, 0, 0, 0},
        '{0, 0, 7, 3, 7, 3, 7, 3, 1, 0, 0, 0}
    };

    line_segment_intersection_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // expected crossing of one pair, exact integer arithmetic
    function automatic crossing_t predict_crossing(input pair_bus_t p);
        longint    v[8];
        longint    dx1, dy1, dx2, dy2, ex, ey, den, na, nb, px, py;
        crossing_t r;
        for (int i = 0; i < 8; i++) begin
            v[i] = longint'($signed(p[16*i +: 16]));
        end
        dx1 = v[2] - v[0];
        dy1 = v[3] - v[1];
        dx2 = v[6] - v[4];
        dy2 = v[7] - v[5];
        ex  = v[0] - v[4];
        ey  = v[1] - v[5];
        den = dy2 * dx1 - dx2 * dy1;
        na  = dx2 * ey - dy2 * ex;
        nb  = dx1 * ey - dy1 * ex;
        r.hit = 1'b0;
        r.x = '0;
        r.y = '0;
        if (den != 0) begin
            if (den < 0) begin
                den = -den;
                na  = -na;
                nb  = -nb;
            end
            if (na >= 0 && nb >= 0 && na <= den && nb <= den) begin
                // SV signed division truncates toward zero
                px = (den * v[0] + na * dx1) / den;
                py = (den * v[1] + na * dy1) / den;
                r.hit = 1'b1;
                r.x = px[lsi_pkg::COORD_BITS-1:0];
                r.y = py[lsi_pkg::COORD_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic pair_bus_t pack_pair(input int c[8]);
        pair_bus_t p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            p[16*i +: 16] = c[i][15:0];
        end
        return p;
    endfunction

    function automatic int pick_coord(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // random pair, mostly shaped so that crossings and special cases occur
    function automatic pair_bus_t random_pair();
        int c[8];
        int kind, cx, cy, k;
        kind = $urandom_range(9);
        for (int i = 0; i < 8; i++) begin
            c[i] = pick_coord(32768);
            if (c[i] > 32767) c[i] = 32767;
        end
        case (kind)
            2, 3, 4, 5: begin
                // both segments inside a small box: crossings are common
                cx = pick_coord(30000);
                cy = pick_coord(30000);
                for (int i = 0; i < 8; i += 2) begin
                    c[i]   = cx + pick_coord(64);
                    c[i+1] = cy + pick_coord(64);
                end
            end
            6: begin
                // parallel or collinear
                c[0] = pick_coord(30000);
                c[1] = pick_coord(30000);
                c[2] = c[0] + pick_coord(100);
                c[3] = c[1] + pick_coord(100);
                k = pick_coord(3);
                c[4] = c[0] + pick_coord(($urandom_range(1) != 0) ? 0 : 200);
                c[5] = c[1] + pick_coord(($urandom_range(1) != 0) ? 0 : 200);
                c[6] = c[4] + k * (c[2] - c[0]);
                c[7] = c[5] + k * (c[3] - c[1]);
            end
            7: begin
                // zero-length segment
                if ($urandom_range(1) != 0) begin
                    c[2] = c[0];
                    c[3] = c[1];
                end else begin
                    c[6] = c[4];
                    c[7] = c[5];
                end
            end
            8: begin
                // shared end point
                c[4] = c[2];
                c[5] = c[3];
            end
            9: begin
                for (int i = 0; i < 8; i++) begin
                    case ($urandom_range(4))
                        0: c[i] = -32768;
                        1: c[i] = 32767;
                        2: c[i] = 0;
                        3: c[i] = -1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return pack_pair(c);
    endfunction

    // present one pair, with random idle cycles before it
    task automatic send_pair(input pair_bus_t p, input bit typed, input crossing_t want);
        sent_pair_t t;
        if ($urandom_range(99) < s_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle);
        end
        t.data = p;
        t.typed = typed;
        t.want = want;
        pairs_in_flight.push_back(t);
        s_tvalid <= 1'b1;
        s_tdata <= p;
        do @(posedge aclk); while (!s_tready);
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= r_idle);
    end

    // input transactions become expectations, output transactions are checked
    always @(posedge aclk) begin
        sent_pair_t t;
        crossing_t  e;
        if (aresetn && s_tvalid && s_tready) begin
            t = pairs_in_flight.pop_front();
            if (t.typed) begin
                crossings_due.push_back(t.want);
            end else begin
                crossings_due.push_back(predict_crossing(t.data));
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (crossings_due.size() == 0) begin
                $display("%0t: unexpected result hit=%b x=%h y=%h", $time,
                         m_tdata[0], m_tdata[16:1], m_tdata[32:17]);
                errors++;
            end else begin
                e = crossings_due.pop_front();
                if (m_tdata[0] !== e.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[16:1] !== e.x) begin
                    $display("%0t: cross_x expected %h actual %h", $time, e.x,
                             m_tdata[16:1]);
                    errors++;
                end
                if (m_tdata[32:17] !== e.y) begin
                    $display("%0t: cross_y expected %h actual %h", $time, e.y,
                             m_tdata[32:17]);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int        c[8];
        crossing_t w;
        int        waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int i = 0; i < 8; i++) c[i] = dir_tab[r][i];
            w.hit = dir_tab[r][9][0];
            w.x = dir_tab[r][10][15:0];
            w.y = dir_tab[r][11][15:0];
            send_pair(pack_pair(c), dir_tab[r][8] != 0, w);
        end

        // random phases: receiver idles, then sender idles, then neither
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                s_idle = 52;
                r_idle = 13;
            end else if (ph == 2) begin
                // let everything drain before the full-rate phase
                s_tvalid <= 1'b0;
                while (crossings_due.size() != 0 || pairs_in_flight.size() != 0)
                    @(posedge aclk);
                s_idle = 0;
                r_idle = 0;
            end
            for (int n = 0; n < 550; n++) begin
                send_pair(random_pair(), 1'b0, w);
            end
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (crossings_due.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (30) @(posedge aclk);
        if (errors == 0 && crossings_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/lsi_pkg.sv
hdl/lsi_front.sv
hdl/lsi_div_cell.sv
hdl/line_segment_intersection_unit.sv
verif/tb.sv
